FILE: hw/rtl/cfr_pkg.sv
// Shared types, constants and the CRC step for the CRC-checked frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 6;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] HdrA = 8'h55;
  localparam logic [ByteW-1:0] HdrB = 8'h00;
  localparam logic [ByteW-1:0] HdrC = 8'hAA;
  localparam logic [ByteW-1:0] HdrD = 8'h00;

  localparam logic [CrcW-1:0] CrcInit     = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPolyRefl = 16'h8408;

  localparam logic [ByteW-1:0] VersionRst = 8'h54;
  localparam logic [LenW-1:0]  MinLenRst  = 6'd4;
  localparam logic [LenW-1:0]  MaxLenRst  = 6'd48;
  localparam logic [ByteW-1:0] LenFloor   = 8'd2;

  // Register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegVersion = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinLen  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxLen  = 2'd2;

  localparam int unsigned OutDataW = 80;

  typedef struct packed {
    logic [ByteW-1:0] protocol_version;
    logic [LenW-1:0]  min_length;
    logic [LenW-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0]  bad_frames;
    logic [CntW-1:0]  good_frames;
    logic             crc_ok;
    logic             frame_end;
    logic [LenW-1:0]  byte_index;
    logic [ByteW-1:0] data_byte;
  } result_t;

  // One byte through the reflected CCITT CRC, LSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPolyRefl;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cfr_cfg_regs.sv
// Configuration registers of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module cfr_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [cfr_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [cfr_pkg::ByteW-1:0]   wr_data_i,
  output cfr_pkg::cfg_t                    cfg_o
);

  cfr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        cfr_pkg::RegVersion: cfg_d.protocol_version = wr_data_i;
        cfr_pkg::RegMinLen:  cfg_d.min_length = wr_data_i[cfr_pkg::LenW-1:0];
        cfr_pkg::RegMaxLen:  cfg_d.max_length = wr_data_i[cfr_pkg::LenW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_version <= cfr_pkg::VersionRst;
      cfg_q.min_length       <= cfr_pkg::MinLenRst;
      cfg_q.max_length       <= cfr_pkg::MaxLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cfr_deframer.sv
// Header hunt, length check, CRC accumulation and frame counting, one byte per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cfr_deframer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cfr_pkg::cfg_t             cfg_i,
  input  wire logic                      in_valid_i,
  input  wire logic [cfr_pkg::ByteW-1:0] rx_byte_i,
  output logic                           res_valid_o,
  output cfr_pkg::result_t               res_o
);

  typedef enum logic [2:0] {
    StHdrA    = 3'd0,
    StHdrB    = 3'd1,
    StHdrC    = 3'd2,
    StHdrD    = 3'd3,
    StVersion = 3'd4,
    StLength  = 3'd5,
    StPayload = 3'd6
  } state_e;

  state_e                    state_q, state_d;
  logic [cfr_pkg::LenW-1:0]  count_q, count_d;
  logic [cfr_pkg::LenW-1:0]  length_q, length_d;
  logic [cfr_pkg::CrcW-1:0]  crc_q, crc_d;
  logic [cfr_pkg::ByteW-1:0] crc_lo_q, crc_lo_d;
  logic [cfr_pkg::CntW-1:0]  good_q, good_d;
  logic [cfr_pkg::CntW-1:0]  bad_q, bad_d;

  logic [cfr_pkg::ByteW-1:0] expect_b;
  logic [cfr_pkg::LenW-1:0]  count_inc;
  logic                      len_ok;
  logic                      crc_match;
  state_e                    retry_st;

  always_comb begin
    case (state_q)
      StHdrA:  expect_b = cfr_pkg::HdrA;
      StHdrB:  expect_b = cfr_pkg::HdrB;
      StHdrC:  expect_b = cfr_pkg::HdrC;
      StHdrD:  expect_b = cfr_pkg::HdrD;
      default: expect_b = cfg_i.protocol_version;
    endcase
  end

  assign retry_st  = (rx_byte_i == cfr_pkg::HdrA) ? StHdrB : StHdrA;
  assign count_inc = count_q + cfr_pkg::LenW'(1);
  assign len_ok    = (rx_byte_i >= cfr_pkg::LenFloor)
                  && (rx_byte_i >= {2'b00, cfg_i.min_length})
                  && (rx_byte_i <= {2'b00, cfg_i.max_length});
  assign crc_match = ({rx_byte_i, crc_lo_q} == crc_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    length_d    = length_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    good_d      = good_q;
    bad_d       = bad_q;
    res_valid_o = 1'b0;
    res_o.data_byte  = rx_byte_i;
    res_o.byte_index = '0;
    res_o.frame_end  = 1'b0;
    res_o.crc_ok     = 1'b0;
    if (in_valid_i) begin
      case (state_q)
        StHdrA, StHdrB, StHdrC, StHdrD, StVersion: begin
          if (rx_byte_i == expect_b) state_d = state_e'(state_q + 3'd1);
          else                       state_d = retry_st;
        end
        StLength: begin
          if (len_ok) begin
            length_d    = rx_byte_i[cfr_pkg::LenW-1:0];
            count_d     = '0;
            crc_d       = cfr_pkg::crc_byte(cfr_pkg::CrcInit, rx_byte_i);
            crc_lo_d    = '0;
            state_d     = StPayload;
            res_valid_o = 1'b1;
          end else begin
            state_d = StHdrA;
          end
        end
        StPayload: begin
          count_d          = count_inc;
          res_valid_o      = 1'b1;
          res_o.byte_index = count_inc;
          if (count_inc >= length_q) begin
            res_o.frame_end = 1'b1;
            res_o.crc_ok    = crc_match;
            if (crc_match) good_d = good_q + cfr_pkg::CntW'(1);
            else           bad_d  = bad_q + cfr_pkg::CntW'(1);
            state_d = StHdrA;
          end else if (count_inc + cfr_pkg::LenW'(1) == length_q) begin
            crc_lo_d = rx_byte_i;
          end else begin
            crc_d = cfr_pkg::crc_byte(crc_q, rx_byte_i);
          end
        end
        default: state_d = StHdrA;
      endcase
    end
    res_o.good_frames = good_d;
    res_o.bad_frames  = bad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StHdrA;
      count_q  <= '0;
      length_q <= '0;
      crc_q    <= cfr_pkg::CrcInit;
      crc_lo_q <= '0;
      good_q   <= '0;
      bad_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      length_q <= length_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      good_q   <= good_d;
      bad_q    <= bad_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cfr_out_buf.sv
// Two-entry result buffer decoupling the byte input from the result stream.
`timescale 1ns / 1ps
`default_nettype none

module cfr_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire cfr_pkg::result_t push_data_i,
  output logic                  not_full_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output cfr_pkg::result_t      out_data_o
);

  cfr_pkg::result_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (fill_q != 2'd0);
  assign not_full_o  = (fill_q != 2'd2);
  assign out_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/crc_checked_frame_receiver.sv
// Top level of the CRC-checked frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received serial byte per transaction, hunts for the header 55 00 AA 00 and the
// version byte, checks the length byte against min_length..max_length (and at least 2), then
// emits the length byte and each payload byte with its index. A reflected CCITT CRC (init
// FFFF, no final xor) covers the length byte and payload up to the last two bytes, which
// carry the received CRC low byte first; the final byte has tlast set and tuser gives the
// CRC result. The hunt step and byte-wide CRC update sit between the input handshake and a
// two-entry result buffer, so a byte can be taken every clock while the buffer has room.
// Good and bad frame counters wrap and ride along with every result. Registers: 0 version,
// 1 minimum length, 2 maximum length; write them only while the block is idle.

module crc_checked_frame_receiver (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [cfr_pkg::ByteW-1:0]     s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] data_byte, [13:8] byte_index, [45:14] good_frames, [77:46] bad_frames, rest zero
  output logic [cfr_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,   // frame_end
  output logic                               m_axis_tuser,   // [0] crc_ok
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [cfr_pkg::ByteW-1:0]     cfg_data_i
);

  cfr_pkg::cfg_t    cfg;
  cfr_pkg::result_t res, out_res;
  logic             in_fire, res_valid, not_full;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = not_full;
  assign in_fire       = s_axis_tvalid && not_full;

  cfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  cfr_deframer u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_fire),
    .rx_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .not_full_o  (not_full),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {2'b00, out_res.bad_frames, out_res.good_frames,
                         out_res.byte_index, out_res.data_byte};
  assign m_axis_tlast = out_res.frame_end;
  assign m_axis_tuser = out_res.crc_ok;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the CRC-checked frame receiver against a local predictor.
`timescale 1ns / 1ps

module testbench;
  import cfr_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned QuietLimit   = 4000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PadLsb       = ByteW + LenW + 2 * CntW;

  typedef enum logic [2:0] {
    HuntA, HuntB, HuntC, HuntD, HuntVersion, HuntLength, InFrame
  } hunt_e;

  typedef struct {
    logic [ByteW-1:0] data_byte;
    logic [LenW-1:0]  byte_index;
    logic             frame_end;
    logic             crc_ok;
    logic [CntW-1:0]  good_frames;
    logic [CntW-1:0]  bad_frames;
  } beat_t;

  class frame_scoreboard;
    logic [ByteW-1:0] version;
    logic [LenW-1:0]  min_len, max_len;
    hunt_e            hunt;
    logic [LenW-1:0]  count, flen;
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] crc_lo;
    logic [CntW-1:0]  good, bad;
    beat_t            expected_q[$];
    int unsigned      mismatches, checked;

    function new();
      version    = VersionRst;
      min_len    = MinLenRst;
      max_len    = MaxLenRst;
      hunt       = HuntA;
      count      = '0;
      flen       = '0;
      crc        = CrcInit;
      crc_lo     = '0;
      good       = '0;
      bad        = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // reflected CCITT, one message bit per pass
    static function logic [CrcW-1:0] crc_step(logic [CrcW-1:0] c, logic [ByteW-1:0] b);
      logic fb;
      for (int i = 0; i < ByteW; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) c = c ^ CrcPolyRefl;
      end
      return c;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        RegVersion: version = val;
        RegMinLen:  min_len = val[LenW-1:0];
        RegMaxLen:  max_len = val[LenW-1:0];
        default: ;
      endcase
    endfunction

    function void add_beat(logic [ByteW-1:0] b, logic [LenW-1:0] idx, logic last, logic ok);
      beat_t e;
      e.data_byte   = b;
      e.byte_index  = idx;
      e.frame_end   = last;
      e.crc_ok      = ok;
      e.good_frames = good;
      e.bad_frames  = bad;
      expected_q.push_back(e);
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      logic [ByteW-1:0] want;
      logic             ok;
      case (hunt)
        HuntA, HuntB, HuntC, HuntD, HuntVersion: begin
          case (hunt)
            HuntA:   want = HdrA;
            HuntB:   want = HdrB;
            HuntC:   want = HdrC;
            HuntD:   want = HdrD;
            default: want = version;
          endcase
          if (b == want) hunt = hunt_e'(hunt + 1);
          else hunt = (b == HdrA) ? HuntB : HuntA;
        end
        HuntLength: begin
          if (b >= LenFloor && b >= min_len && b <= max_len) begin
            flen   = b[LenW-1:0];
            count  = '0;
            crc    = crc_step(CrcInit, b);
            crc_lo = '0;
            hunt   = InFrame;
            add_beat(b, '0, 1'b0, 1'b0);
          end else begin
            hunt = HuntA;
          end
        end
        InFrame: begin
          count = count + 1'b1;
          if (count >= flen) begin
            ok = ({b, crc_lo} == crc);
            if (ok) good = good + 1'b1;
            else bad = bad + 1'b1;
            hunt = HuntA;
            add_beat(b, count, 1'b1, ok);
          end else begin
            if (count + 1 == flen) crc_lo = b;
            else crc = crc_step(crc, b);
            add_beat(b, count, 1'b0, 1'b0);
          end
        end
        default: hunt = HuntA;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic last, logic user);
      beat_t e, g;
      g.data_byte   = data[ByteW-1:0];
      g.byte_index  = data[ByteW +: LenW];
      g.good_frames = data[ByteW+LenW +: CntW];
      g.bad_frames  = data[ByteW+LenW+CntW +: CntW];
      g.frame_end   = last;
      g.crc_ok      = user;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte %h idx %0d end %b ok %b",
                         g.data_byte, g.byte_index, g.frame_end, g.crc_ok));
        return;
      end
      e = expected_q.pop_front();
      if (g.data_byte !== e.data_byte || g.byte_index !== e.byte_index ||
          g.frame_end !== e.frame_end || g.crc_ok !== e.crc_ok ||
          g.good_frames !== e.good_frames || g.bad_frames !== e.bad_frames ||
          data[OutDataW-1:PadLsb] !== '0)
        report($sformatf({"expected byte %h idx %0d end %b ok %b good %0d bad %0d; ",
                          "got byte %h idx %0d end %b ok %b good %0d bad %0d pad %b"},
                         e.data_byte, e.byte_index, e.frame_end, e.crc_ok,
                         e.good_frames, e.bad_frames,
                         g.data_byte, g.byte_index, g.frame_end, g.crc_ok,
                         g.good_frames, g.bad_frames, data[OutDataW-1:PadLsb]));
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ByteW-1:0]      s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [ByteW-1:0]      cfg_data_i    = '0;

  frame_scoreboard sb = new();
  int unsigned idle_pct = 0, stall_pct = 0;
  int unsigned sent = 0, settings = 0, quiet = 0;

  crc_checked_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // inputs noted before results are checked, so a same-edge transaction cannot race
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) sb.note_config(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (cfg_valid_i && cfg_ready_o) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet);
        $display("status: fail");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ByteW-1:0] ver, minv, maxv);
    write_reg(RegVersion, ver);
    write_reg(RegMinLen, minv);
    write_reg(RegMaxLen, maxv);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // hold the sender off until every predicted result is back
  task automatic settle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic send_header(input logic [ByteW-1:0] ver);
    send_byte(HdrA);
    send_byte(HdrB);
    send_byte(HdrC);
    send_byte(HdrD);
    send_byte(ver);
  endtask

  task automatic send_frame(input logic [ByteW-1:0] ver, input int unsigned len,
                            input bit corrupt);
    logic [CrcW-1:0]  c;
    logic [ByteW-1:0] p;
    send_header(ver);
    send_byte(ByteW'(len));
    c = frame_scoreboard::crc_step(CrcInit, ByteW'(len));
    for (int i = 1; i + 1 < len; i++) begin
      p = ByteW'($urandom_range(255));
      send_byte(p);
      c = frame_scoreboard::crc_step(c, p);
    end
    if (len < 2) return;
    if (corrupt) c = c ^ (16'd1 << $urandom_range(15));
    send_byte(c[ByteW-1:0]);
    send_byte(c[CrcW-1:ByteW]);
  endtask

  task automatic send_unit();
    int unsigned      kind, lo, hi, len, n;
    logic [ByteW-1:0] ver, b;
    logic [ByteW-1:0] hdr [4];
    hdr  = '{HdrA, HdrB, HdrC, HdrD};
    kind = $urandom_range(99);
    lo   = (sb.min_len < LenFloor) ? 32'(LenFloor) : 32'(sb.min_len);
    hi   = 32'(sb.max_len);
    ver  = sb.version;
    if (kind < 65) begin
      if (lo > hi) len = $urandom_range(63);
      else if ($urandom_range(4) != 0) len = $urandom_range((hi < lo + 10) ? hi : lo + 10, lo);
      else len = $urandom_range(hi, lo);
      send_frame(ver, len, $urandom_range(4) == 0);
    end else if (kind < 75) begin
      case ($urandom_range(3))
        0:       len = $urandom_range(1);
        1:       len = lo - 1;
        2:       len = hi + 1;
        default: len = $urandom_range(255, 62);
      endcase
      send_header(ver);
      send_byte(ByteW'(len));
    end else if (kind < 85) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) send_byte(hdr[i]);
      b = ByteW'($urandom_range(255, 1));
      if (n == 4) b = ver ^ b;
      send_byte(b);
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        b = ($urandom_range(3) == 0) ? HdrA : ByteW'($urandom_range(255));
        send_byte(b);
      end
    end
  endtask

  task automatic run_phase(input int unsigned n, idle, stall, input bit pressure);
    int unsigned start;
    bit          paused;
    idle_pct  = idle;
    stall_pct = stall;
    start     = sent;
    paused    = 1'b0;
    while (sent - start < n) begin
      if (pressure && !paused && sent - start >= n / 2) begin
        settle(0);
        paused = 1'b1;
      end
      send_unit();
    end
    settle(SettleCycles);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // repeated first header byte, then a first header byte in place of the version that restarts the header
    send_byte(HdrA);
    send_byte(HdrA);
    send_byte(HdrB);
    send_byte(HdrC);
    send_byte(HdrD);
    send_frame(VersionRst, 4, 1'b0);
    // oversized length 0x55 must not count as a first header byte
    send_header(VersionRst);
    send_byte(HdrA);
    send_byte(HdrB);
    send_byte(HdrC);
    send_byte(HdrD);
    send_byte(VersionRst);
    run_phase(100, 0, 0, 1'b0);

    write_reg(RegSpare, 8'hA5);
    configure(8'h54, 8'hC2, 8'h7D);
    run_phase(120, 68, 0, 1'b0);

    configure(8'hFF, 8'h00, 8'h08);
    send_header(8'hFF);
    send_byte(8'd0);
    send_header(8'hFF);
    send_byte(8'd1);
    run_phase(110, 0, 68, 1'b1);

    configure(8'h00, 8'h3D, 8'hFD);
    run_phase(140, 12, 12, 1'b0);

    configure(8'h55, 8'h14, 8'h0A);
    run_phase(90, 0, 0, 1'b0);

    configure(8'hAA, 8'h04, 8'h30);
    run_phase(120, 68, 68, 1'b0);

    $display("summary: %0d bytes sent over %0d register settings, %0d results checked",
             sent, settings + 1, sb.checked);
    $display("summary: %0d frames with good crc, %0d with bad crc", sb.good, sb.bad);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", sb.mismatches, sb.pending());
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: crc_checked_frame_receiver.f
hw/rtl/cfr_pkg.sv
hw/rtl/cfr_cfg_regs.sv
hw/rtl/cfr_deframer.sv
hw/rtl/cfr_out_buf.sv
hw/rtl/crc_checked_frame_receiver.sv
bench/testbench.sv
